// ===== rtl/rqr_pkg.sv =====
// Package for the ready queue: operation codes, cell command type and parameter defaults.
`timescale 1ns / 1ps
`default_nettype none

package rqr_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int ID_WIDTH_DEFAULT = 8;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_TAKE   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Command broadcast to every cell in the chain for one operation.
   typedef struct packed {
      logic append;
      logic take;
      logic remove;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/rqr_cell.sv =====
// One queue slot: holds an identifier and its valid bit, shifts toward the head on demand.
`timescale 1ns / 1ps
`default_nettype none

module rqr_cell #(
   parameter int ID_WIDTH = rqr_pkg::ID_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rqr_pkg::cell_cmd_type cmd,
   input  wire logic [ID_WIDTH-1:0]   key,
   input  wire logic                  prev_valid,
   input  wire logic [ID_WIDTH-1:0]   next_id,
   input  wire logic                  next_valid,
   input  wire logic                  seen_in,
   output logic                       seen_out,
   output logic [ID_WIDTH-1:0]        id_out,
   output logic                       valid_out
);

   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic                valid_ff, valid_in;
   logic                hit, shift, load;

   assign hit      = valid_ff && (id_ff == key);
   assign seen_out = seen_in || hit;

   // A removal closes the gap from the first match toward the tail.
   assign shift = cmd.take || (cmd.remove && seen_out);
   // The first free slot after the last valid one takes an appended entry.
   assign load  = cmd.append && prev_valid && !valid_ff;

   always_comb begin
      id_in    = id_ff;
      valid_in = valid_ff;
      if (shift) begin
         id_in    = next_id;
         valid_in = next_valid;
      end else if (load) begin
         id_in    = key;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id_out    = id_ff;
   assign valid_out = valid_ff;

endmodule

`default_nettype wire

// ===== rtl/ready_queue_with_remove_unit.sv =====
// Top level of the ready queue: chain of slot cells, occupancy count and result register.
// One operation is taken on every clock cycle in which start is high; busy never rises.
// The result of an operation is on the rsp_ ports with rsp_valid high in the cycle right
// after the start cycle, and the rate is one operation per cycle.
// Match search, shift and append all happen in a single pass through the chain of DEPTH
// cells, whose first-match signal ripples from the head cell to the tail cell. The
// receiver cannot stall: every result is shown for exactly one cycle and must be taken.
`timescale 1ns / 1ps
`default_nettype none

module ready_queue_with_remove_unit #(
   parameter int DEPTH    = rqr_pkg::DEPTH_DEFAULT,
   parameter int ID_WIDTH = rqr_pkg::ID_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_thread_id,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_thread,
   output logic            rsp_out_valid,
   output logic            rsp_found,
   output logic            rsp_full_drop,
   output logic            rsp_empty_res,
   output logic [4:0]      rsp_queue_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   rqr_pkg::cell_cmd_type cmd;
   logic                  accept;
   logic [ID_WIDTH+7:0]   key_ext;
   logic [ID_WIDTH-1:0]   key;

   logic [ID_WIDTH-1:0]   cell_id    [DEPTH];
   logic                  cell_valid [DEPTH];
   logic [DEPTH:0]        seen;

   logic                  head_valid, full, found, took;
   logic [ID_WIDTH+7:0]   head_ext;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W+4:0]      count_ext;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            out_thread_ff, out_thread_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  found_ff, found_in;
   logic                  drop_ff, drop_in;
   logic                  empty_ff, empty_in;
   logic [4:0]            count_res_ff, count_res_in;

   assign busy   = 1'b0;
   assign accept = start;

   assign cmd.append = accept && (req_operation == rqr_pkg::OP_APPEND);
   assign cmd.take   = accept && (req_operation == rqr_pkg::OP_TAKE);
   assign cmd.remove = accept && (req_operation == rqr_pkg::OP_REMOVE);

   assign key_ext = {ID_WIDTH'(0), req_thread_id};
   assign key     = key_ext[ID_WIDTH-1:0];

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                prev_v;
      logic [ID_WIDTH-1:0] nxt_id;
      logic                nxt_v;

      if (i == 0) begin : g_head
         assign prev_v = 1'b1;
      end else begin : g_body
         assign prev_v = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign nxt_id = '0;
         assign nxt_v  = 1'b0;
      end else begin : g_inner
         assign nxt_id = cell_id[i+1];
         assign nxt_v  = cell_valid[i+1];
      end

      rqr_cell #(
         .ID_WIDTH(ID_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .key       (key),
         .prev_valid(prev_v),
         .next_id   (nxt_id),
         .next_valid(nxt_v),
         .seen_in   (seen[i]),
         .seen_out  (seen[i+1]),
         .id_out    (cell_id[i]),
         .valid_out (cell_valid[i])
      );
   end

   assign head_valid = cell_valid[0];
   assign full       = cell_valid[DEPTH-1];
   assign found      = cmd.remove && seen[DEPTH];
   assign took       = cmd.take && head_valid;
   assign head_ext   = {8'd0, cell_id[0]};

   always_comb begin
      count_in = count_ff;
      if (cmd.append && !full) begin
         count_in = count_ff + CNT_W'(1);
      end else if (took || found) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_ext = {5'd0, count_in};

   always_comb begin
      rsp_valid_in  = accept;
      out_thread_in = took ? head_ext[7:0] : 8'd0;
      out_valid_in  = took;
      found_in      = found;
      drop_in       = cmd.append && full;
      empty_in      = (count_in == '0);
      count_res_in  = count_ext[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the last result when no operation is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         out_thread_ff <= out_thread_in;
         out_valid_ff  <= out_valid_in;
         found_ff      <= found_in;
         drop_ff       <= drop_in;
         empty_ff      <= empty_in;
         count_res_ff  <= count_res_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_thread  = out_thread_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_full_drop   = drop_ff;
   assign rsp_empty_res   = empty_ff;
   assign rsp_queue_count = count_res_ff;

endmodule

`default_nettype wire
